/* src/lcwt_pkg.sv */
// Shared constants for the load cell weigh and tare readout.
package lcwt_pkg;

    localparam int WEIGH_SAMPLES = 3;
    localparam int TARE_SAMPLES  = 50;
    localparam int DATA_BITS     = 24;

    localparam int SUM_W   = 31;
    localparam int CNT_W   = 8;
    localparam int BIT_W   = 5;
    localparam int TOUT_W  = 10;
    localparam int SCALE_W = 24;
    localparam int WEIGHT_W = 32;

    localparam int CNT_MAX = (TARE_SAMPLES > WEIGH_SAMPLES) ? TARE_SAMPLES : WEIGH_SAMPLES;

    // floor(x / n) == (x * DIV_MUL) >> DIV_SHIFT for any 31-bit x
    localparam int DIV_SHIFT_W = SUM_W + $clog2(WEIGH_SAMPLES);
    localparam int DIV_SHIFT_T = SUM_W + $clog2(TARE_SAMPLES);
    localparam logic [31:0] DIV_MUL_W =
        32'(((64'd1 << DIV_SHIFT_W) + 64'(WEIGH_SAMPLES) - 64'd1) / 64'(WEIGH_SAMPLES));
    localparam logic [31:0] DIV_MUL_T =
        32'(((64'd1 << DIV_SHIFT_T) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES));

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WEIGH = 2'd1;
    localparam logic [1:0] CMD_TARE  = 2'd2;

    localparam logic CFG_SCALE   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 24'd56719;
    localparam logic [TOUT_W-1:0]    TIMEOUT_RESET = 10'd200;
    localparam logic [DATA_BITS-1:0] TARE_RESET    = 24'd8467416;
    localparam logic [DATA_BITS-1:0] SIGN_FLIP     = 24'h800000;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN_MAG = 32'h8000_0000;

endpackage

/* src/load_cell_weigh_and_tare_top.sv */
// Load cell bridge converter readout with weigh and tare runs.
//
// Usage: one input word per serial clock half period (s_cmd, s_dout_level,
// s_ms_strobe) on a valid/ready channel; one result word per input word on
// the m_ channel. s_cmd weigh or tare starts a run when idle; m_sck_level is
// the level to drive on the converter clock for that half period.
// The config port (cfg_we, cfg_index, cfg_data) sets the Q8.16 scale and the
// data-ready timeout in ms; write it only while no run is active.
// Throughput: one word per cycle unless the receiver stalls; the readout
// sequencer updates at accept, the average (reciprocal multiply), tare subtract,
// scale multiply and saturation follow in a 4-stage pipeline behind it.
// When the receiver stalls, results hold and words keep being accepted until
// the pipeline is full, then s_ready drops; nothing is lost.
// Reset (aresetn low, synchronous) empties the pipeline, returns to idle,
// restores default config, weight 0 and the default tare.
module load_cell_weigh_and_tare_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_dout_level,
    input  logic        s_ms_strobe,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sck_level,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic signed [31:0] m_weight_mg,
    output logic        m_timeout_seen,
    output logic [23:0] m_tare_value
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT, PH_HI, PH_LO, PH_XHI, PH_XLO
    } phase_t;

    typedef struct packed {
        logic sck;
        logic busy;
        logic done;
        logic tout;
        logic fin_weigh;
        logic fin_tare;
    } flags_t;

    localparam int DW = lcwt_pkg::DATA_BITS;

    // config
    logic [lcwt_pkg::SCALE_W-1:0] scale_reg;
    logic [lcwt_pkg::TOUT_W-1:0]  timeout_reg;

    // sequencer state
    phase_t                       phase_reg, phase_next;
    logic [lcwt_pkg::BIT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0]                sample_reg, sample_next;
    logic [lcwt_pkg::CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [lcwt_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [lcwt_pkg::TOUT_W-1:0]  wait_cnt_reg, wait_cnt_next;
    logic                         run_tare_reg, run_tare_next;
    logic                         tout_reg, tout_next;

    // pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic en1, en2, en3, en4, en_o, acc;
    flags_t f1_reg, f2_reg, f3_reg, f4_reg, fo_reg;
    flags_t f0;
    logic [lcwt_pkg::SUM_W-1:0]   sum1_reg;
    logic [62:0]                  prod2_reg;
    logic [DW-1:0]                mag3_reg, tare3_reg, tare4_reg, tareo_reg;
    logic                         neg3_reg, neg4_reg;
    logic [47:0]                  prod4_reg;
    logic [DW-1:0]                tare_store_reg;
    logic [lcwt_pkg::WEIGHT_W-1:0] weight_reg;

    // sequencer combinational
    logic                         rd_done;
    logic [DW-1:0]                raw;
    logic [lcwt_pkg::SUM_W-1:0]   sum_add;
    logic [lcwt_pkg::CNT_W-1:0]   cnt_inc, n_sel;

    // datapath combinational
    logic [31:0]                  mul_c;
    logic [DW-1:0]                avg;
    logic [DW:0]                  diff;
    logic [31:0]                  q, w_sat;

    assign en_o    = !vo_reg || m_ready;
    assign en4     = !v4_reg || en_o;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign acc     = s_valid && en1;

    always_comb begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        sample_next   = sample_reg;
        rd_cnt_next   = rd_cnt_reg;
        sum_next      = sum_reg;
        wait_cnt_next = wait_cnt_reg;
        run_tare_next = run_tare_reg;
        tout_next     = tout_reg;
        rd_done       = 1'b0;
        raw           = '0;
        f0            = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (s_cmd == lcwt_pkg::CMD_WEIGH || s_cmd == lcwt_pkg::CMD_TARE) begin
                    run_tare_next = (s_cmd == lcwt_pkg::CMD_TARE);
                    rd_cnt_next   = '0;
                    sum_next      = '0;
                    wait_cnt_next = '0;
                    tout_next     = 1'b0;
                    bit_cnt_next  = '0;
                    sample_next   = '0;
                    phase_next    = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!s_dout_level) begin
                    bit_cnt_next = '0;
                    sample_next  = '0;
                    phase_next   = PH_HI;
                end else if (s_ms_strobe) begin
                    if (wait_cnt_reg >= timeout_reg) begin
                        tout_next = 1'b1;
                        rd_done   = 1'b1;
                    end else begin
                        wait_cnt_next = wait_cnt_reg + 1'b1;
                    end
                end
            end
            PH_HI: begin
                if (bit_cnt_reg != '0) begin
                    sample_next = {sample_reg[DW-2:0], s_dout_level};
                end
                f0.sck       = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                phase_next   = PH_LO;
            end
            PH_LO: begin
                phase_next = (bit_cnt_reg >= lcwt_pkg::BIT_W'(DW)) ? PH_XHI : PH_HI;
            end
            PH_XHI: begin
                sample_next = {sample_reg[DW-2:0], s_dout_level};
                f0.sck      = 1'b1;
                phase_next  = PH_XLO;
            end
            PH_XLO: begin
                rd_done = 1'b1;
                raw     = sample_reg ^ lcwt_pkg::SIGN_FLIP;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        n_sel   = run_tare_reg ? lcwt_pkg::CNT_W'(lcwt_pkg::TARE_SAMPLES)
                               : lcwt_pkg::CNT_W'(lcwt_pkg::WEIGH_SAMPLES);
        sum_add = sum_reg + lcwt_pkg::SUM_W'(raw);
        cnt_inc = rd_cnt_reg + 1'b1;
        if (rd_done) begin
            sum_next      = sum_add;
            rd_cnt_next   = cnt_inc;
            bit_cnt_next  = '0;
            sample_next   = '0;
            wait_cnt_next = '0;
            if (cnt_inc >= n_sel) begin
                phase_next   = PH_IDLE;
                f0.done      = 1'b1;
                f0.fin_weigh = !run_tare_reg;
                f0.fin_tare  = run_tare_reg;
            end else begin
                phase_next = PH_WAIT;
            end
        end
        f0.busy = (phase_next != PH_IDLE);
        f0.tout = tout_next;
    end

    // datapath stages
    assign mul_c = f1_reg.fin_tare ? lcwt_pkg::DIV_MUL_T : lcwt_pkg::DIV_MUL_W;
    assign avg   = f2_reg.fin_tare ? DW'(prod2_reg >> lcwt_pkg::DIV_SHIFT_T)
                                   : DW'(prod2_reg >> lcwt_pkg::DIV_SHIFT_W);
    assign diff  = {1'b0, avg} - {1'b0, tare_store_reg};
    assign q     = prod4_reg[47:16];

    always_comb begin
        if (neg4_reg) begin
            w_sat = 32'd0 - ((q > lcwt_pkg::WEIGHT_MIN_MAG) ? lcwt_pkg::WEIGHT_MIN_MAG : q);
        end else begin
            w_sat = (q > lcwt_pkg::WEIGHT_MAX) ? lcwt_pkg::WEIGHT_MAX : q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= lcwt_pkg::SCALE_RESET;
            timeout_reg    <= lcwt_pkg::TIMEOUT_RESET;
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            sample_reg     <= '0;
            rd_cnt_reg     <= '0;
            sum_reg        <= '0;
            wait_cnt_reg   <= '0;
            run_tare_reg   <= 1'b0;
            tout_reg       <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            vo_reg         <= 1'b0;
            tare_store_reg <= lcwt_pkg::TARE_RESET;
            weight_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lcwt_pkg::CFG_SCALE:   scale_reg   <= cfg_data;
                    lcwt_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[lcwt_pkg::TOUT_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                phase_reg    <= phase_next;
                bit_cnt_reg  <= bit_cnt_next;
                sample_reg   <= sample_next;
                rd_cnt_reg   <= rd_cnt_next;
                sum_reg      <= sum_next;
                wait_cnt_reg <= wait_cnt_next;
                run_tare_reg <= run_tare_next;
                tout_reg     <= tout_next;
            end
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en_o) vo_reg <= v4_reg;
            if (en3 && v2_reg && f2_reg.fin_tare) begin
                tare_store_reg <= avg;
            end
            if (en_o && v4_reg && f4_reg.fin_weigh) begin
                weight_reg <= w_sat;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (en1) begin
            f1_reg   <= f0;
            sum1_reg <= sum_next;
        end
        if (en2) begin
            f2_reg    <= f1_reg;
            prod2_reg <= 63'(sum1_reg) * 63'(mul_c);
        end
        if (en3) begin
            f3_reg    <= f2_reg;
            neg3_reg  <= diff[DW];
            mag3_reg  <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
            tare3_reg <= f2_reg.fin_tare ? avg : tare_store_reg;
        end
        if (en4) begin
            f4_reg    <= f3_reg;
            neg4_reg  <= neg3_reg;
            prod4_reg <= 48'(mag3_reg) * 48'(scale_reg);
            tare4_reg <= tare3_reg;
        end
        if (en_o) begin
            fo_reg    <= f4_reg;
            tareo_reg <= tare4_reg;
        end
    end

    assign m_valid        = vo_reg;
    assign m_sck_level    = fo_reg.sck;
    assign m_busy_res     = fo_reg.busy;
    assign m_done_res     = fo_reg.done;
    assign m_timeout_seen = fo_reg.tout;
    assign m_tare_value   = tareo_reg;
    assign m_weight_mg    = weight_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done result reports busy");

    a_bit_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg <= lcwt_pkg::BIT_W'(DW))
        else $error("bit count past data width");

    a_rd_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_cnt_reg <= lcwt_pkg::CNT_W'(lcwt_pkg::CNT_MAX))
        else $error("reading count past sample count");

    a_xhi_to_xlo: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && phase_reg == PH_XHI |=> phase_reg == PH_XLO)
        else $error("extra pulse not followed by completion");

    a_fin_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> !(f4_reg.fin_weigh && f4_reg.fin_tare))
        else $error("run finished as weigh and tare");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the load cell weigh/tare readout: directed table, then random runs.
module testbench;

    typedef enum logic [2:0] {ST_IDLE, ST_WAIT, ST_HI, ST_LO, ST_XHI, ST_XLO} seq_t;

    typedef struct packed {
        logic               sck;
        logic               busy;
        logic               done;
        logic signed [31:0] weight;
        logic               tout;
        logic [23:0]        tare;
    } readout_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       dout;
        logic       strobe;
    } tick_t;

    typedef struct packed {
        tick_t    word;
        logic     typed;
        readout_t want;
    } plan_row_t;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 80;
    localparam int PLAN_ROWS   = 18;

    localparam readout_t AT_RESET  = {1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, lcwt_pkg::TARE_RESET};
    localparam readout_t RUN_START = {1'b0, 1'b1, 1'b0, 32'sd0, 1'b0, lcwt_pkg::TARE_RESET};
    localparam readout_t UNTYPED   = '0;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_we       = 1'b0;
    logic        cfg_index    = lcwt_pkg::CFG_SCALE;
    logic [23:0] cfg_data     = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd        = lcwt_pkg::CMD_TICK;
    logic        s_dout_level = 1'b1;
    logic        s_ms_strobe  = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_sck_level;
    logic        m_busy_res;
    logic        m_done_res;
    logic signed [31:0] m_weight_mg;
    logic        m_timeout_seen;
    logic [23:0] m_tare_value;

    // readout sequencer mirror
    seq_t        ph_q       = ST_IDLE;
    logic [4:0]  bits_q     = '0;
    logic [23:0] shreg_q    = '0;
    logic [7:0]  nread_q    = '0;
    logic [30:0] sum_q      = '0;
    logic [9:0]  wcnt_q     = '0;
    logic        is_tare_q  = 1'b0;
    logic        tlatch_q   = 1'b0;
    logic [23:0] tare_q     = lcwt_pkg::TARE_RESET;
    logic signed [31:0] weight_q = '0;
    logic [23:0] cfg_scale  = lcwt_pkg::SCALE_RESET;
    logic [9:0]  cfg_tout   = lcwt_pkg::TIMEOUT_RESET;

    // stimulus shaping
    logic        starve_run = 1'b0;
    logic [2:0]  run_mode   = '0;
    logic [1:0]  bit_mode   = '0;
    logic        calm       = 1'b0;

    readout_t    expected_readouts[$];
    readout_t    got_word;
    readout_t    want_word;
    int          mismatches = 0;
    logic [23:0] scale_plan [PHASES];
    logic [9:0]  tout_plan  [PHASES];

    plan_row_t plan [PLAN_ROWS] = '{
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b0, 1'b1, AT_RESET},
        {CMD_SPARE,           1'b0, 1'b1, 1'b1, AT_RESET},
        {lcwt_pkg::CMD_WEIGH, 1'b1, 1'b0, 1'b1, RUN_START},
        {lcwt_pkg::CMD_TARE,  1'b1, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b0, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_WEIGH, 1'b1, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TARE,  1'b0, 1'b0, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b0, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b0, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b0, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b0, 1'b0, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_WEIGH, 1'b1, 1'b1, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b1, 1'b0, 1'b0, UNTYPED},
        {lcwt_pkg::CMD_TICK,  1'b0, 1'b0, 1'b0, UNTYPED}
    };

    load_cell_weigh_and_tare_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_dout_level   (s_dout_level),
        .s_ms_strobe    (s_ms_strobe),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sck_level    (m_sck_level),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_weight_mg    (m_weight_mg),
        .m_timeout_seen (m_timeout_seen),
        .m_tare_value   (m_tare_value)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [31:0] scaled_weight(logic [23:0] avg);
        longint diff;
        longint mag;
        longint q;
        diff = longint'(avg) - longint'(tare_q);
        mag  = (diff < 0) ? -diff : diff;
        q    = (mag * longint'(cfg_scale)) >>> 16;
        if (diff < 0) begin
            if (q > longint'(lcwt_pkg::WEIGHT_MIN_MAG)) q = longint'(lcwt_pkg::WEIGHT_MIN_MAG);
            return 32'(-q);
        end
        if (q > longint'(lcwt_pkg::WEIGHT_MAX)) q = longint'(lcwt_pkg::WEIGHT_MAX);
        return 32'(q);
    endfunction

    function automatic logic close_reading(logic [23:0] raw);
        logic [30:0] n;
        logic [30:0] avg;
        n        = is_tare_q ? 31'(lcwt_pkg::TARE_SAMPLES) : 31'(lcwt_pkg::WEIGH_SAMPLES);
        sum_q    = sum_q + 31'(raw);
        nread_q  = nread_q + 8'd1;
        bits_q   = '0;
        shreg_q  = '0;
        wcnt_q   = '0;
        if (31'(nread_q) >= n) begin
            avg = sum_q / n;
            if (is_tare_q) tare_q = avg[23:0];
            else weight_q = scaled_weight(avg[23:0]);
            ph_q = ST_IDLE;
            return 1'b1;
        end
        ph_q = ST_WAIT;
        return 1'b0;
    endfunction

    function automatic readout_t step_readout(tick_t w);
        readout_t r;
        logic     sck;
        logic     fin;
        sck = 1'b0;
        fin = 1'b0;
        case (ph_q)
            ST_IDLE: begin
                if (w.cmd == lcwt_pkg::CMD_WEIGH || w.cmd == lcwt_pkg::CMD_TARE) begin
                    is_tare_q = (w.cmd == lcwt_pkg::CMD_TARE);
                    nread_q   = '0;
                    sum_q     = '0;
                    wcnt_q    = '0;
                    tlatch_q  = 1'b0;
                    bits_q    = '0;
                    shreg_q   = '0;
                    ph_q      = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!w.dout) begin
                    bits_q  = '0;
                    shreg_q = '0;
                    ph_q    = ST_HI;
                end else if (w.strobe) begin
                    if (wcnt_q >= cfg_tout) begin
                        tlatch_q = 1'b1;
                        fin = close_reading(24'd0);
                    end else begin
                        wcnt_q = wcnt_q + 10'd1;
                    end
                end
            end
            ST_HI: begin
                if (bits_q > 0) shreg_q = {shreg_q[22:0], w.dout};
                sck    = 1'b1;
                bits_q = bits_q + 5'd1;
                ph_q   = ST_LO;
            end
            ST_LO: ph_q = (bits_q >= lcwt_pkg::DATA_BITS) ? ST_XHI : ST_HI;
            ST_XHI: begin
                shreg_q = {shreg_q[22:0], w.dout};
                sck     = 1'b1;
                ph_q    = ST_XLO;
            end
            ST_XLO: fin = close_reading(shreg_q ^ lcwt_pkg::SIGN_FLIP);
            default: ph_q = ST_IDLE;
        endcase
        r.sck    = sck;
        r.busy   = (ph_q != ST_IDLE);
        r.done   = fin;
        r.weight = weight_q;
        r.tout   = tlatch_q;
        r.tare   = tare_q;
        return r;
    endfunction

    // Mostly well-formed traffic: starts when idle, a data line that drops, bit patterns
    // that hit the extremes; wind_down stops new runs and hurries the current one.
    // Tare runs only start where the timeout is short, so they can be cut short.
    function automatic tick_t pick_word(logic wind_down);
        tick_t w;
        int    roll;
        roll     = $urandom_range(99);
        w.cmd    = lcwt_pkg::CMD_TICK;
        w.dout   = 1'($urandom_range(1));
        w.strobe = ($urandom_range(99) < 30);
        case (ph_q)
            ST_IDLE: begin
                if (!wind_down) begin
                    if (roll < 25) w.cmd = lcwt_pkg::CMD_WEIGH;
                    else if (roll < 37)
                        w.cmd = (cfg_tout <= 8) ? lcwt_pkg::CMD_TARE : lcwt_pkg::CMD_TICK;
                    else if (roll < 42) w.cmd = CMD_SPARE;
                    if (w.cmd == lcwt_pkg::CMD_WEIGH || w.cmd == lcwt_pkg::CMD_TARE) begin
                        starve_run = (cfg_tout <= 8) &&
                                     ($urandom_range(99) <
                                      ((w.cmd == lcwt_pkg::CMD_TARE) ? 70 : 25));
                        run_mode   = 3'($urandom_range(4));
                        bit_mode   = run_mode[1:0];
                    end
                end
            end
            ST_WAIT: begin
                if (roll < 10) w.cmd = 2'($urandom_range(3));
                if (wind_down && cfg_tout <= 8) begin
                    w.dout   = 1'b1;
                    w.strobe = 1'b1;
                end else if (starve_run) begin
                    w.dout   = ($urandom_range(99) < 95);
                    w.strobe = ($urandom_range(99) < 80);
                end else if (wind_down) begin
                    w.dout = 1'b0;
                end else begin
                    w.dout = ($urandom_range(99) >= 40);
                end
                if (!w.dout) bit_mode = (run_mode == 3'd4) ? 2'($urandom_range(3)) : run_mode[1:0];
            end
            default: begin
                if (roll < 10) w.cmd = 2'($urandom_range(3));
                case (bit_mode)
                    2'd0: w.dout = 1'($urandom_range(1));
                    2'd1: w.dout = 1'b1;
                    2'd2: w.dout = 1'b0;
                    default: w.dout = !(ph_q == ST_HI && bits_q == 5'd1);
                endcase
            end
        endcase
        return w;
    endfunction

    task automatic send_word(tick_t w, logic typed, readout_t want);
        readout_t r;
        s_valid      <= 1'b1;
        s_cmd        <= w.cmd;
        s_dout_level <= w.dout;
        s_ms_strobe  <= w.strobe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = step_readout(w);
        expected_readouts.push_back(typed ? want : r);
    endtask

    task automatic pace_gap();
        if (!calm) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge aclk);
    endtask

    task automatic load_settings(logic [23:0] scale, logic [9:0] tout);
        cfg_we    <= 1'b1;
        cfg_index <= lcwt_pkg::CFG_SCALE;
        cfg_data  <= scale;
        @(posedge aclk);
        cfg_index <= lcwt_pkg::CFG_TIMEOUT;
        cfg_data  <= 24'(tout);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_scale = scale;
        cfg_tout  = tout;
    endtask

    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_word = {m_sck_level, m_busy_res, m_done_res, m_weight_mg,
                        m_timeout_seen, m_tare_value};
            if (expected_readouts.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want_word = expected_readouts.pop_front();
                if (got_word.sck !== want_word.sck) begin
                    $error("sck_level: expected %0d, got %0d", want_word.sck, got_word.sck);
                    mismatches++;
                end
                if (got_word.busy !== want_word.busy) begin
                    $error("busy_res: expected %0d, got %0d", want_word.busy, got_word.busy);
                    mismatches++;
                end
                if (got_word.done !== want_word.done) begin
                    $error("done_res: expected %0d, got %0d", want_word.done, got_word.done);
                    mismatches++;
                end
                if (got_word.weight !== want_word.weight) begin
                    $error("weight_mg: expected %0d, got %0d",
                           want_word.weight, got_word.weight);
                    mismatches++;
                end
                if (got_word.tout !== want_word.tout) begin
                    $error("timeout_seen: expected %0d, got %0d", want_word.tout, got_word.tout);
                    mismatches++;
                end
                if (got_word.tare !== want_word.tare) begin
                    $error("tare_value: expected %0d, got %0d", want_word.tare, got_word.tare);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL load_cell_weigh_and_tare_top");
        $finish;
    end

    initial begin
        int p;
        int i;
        scale_plan = '{lcwt_pkg::SCALE_RESET, 24'hFFFFFF, 24'd0, 24'($urandom),
                       24'd65536, 24'($urandom)};
        tout_plan  = '{10'd1, 10'd0, 10'd2, 10'd1023, 10'd3, 10'($urandom_range(6, 1))};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        load_settings(scale_plan[0], tout_plan[0]);
        for (i = 0; i < PLAN_ROWS; i++) begin
            pace_gap();
            send_word(plan[i].word, plan[i].typed, plan[i].want);
        end
        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                load_settings(scale_plan[p], tout_plan[p]);
            end
            calm = (p == 3);
            for (i = 0; i < PHASE_WORDS; i++) begin
                pace_gap();
                send_word(pick_word(1'b0), 1'b0, UNTYPED);
            end
            while (ph_q != ST_IDLE) begin
                pace_gap();
                send_word(pick_word(1'b1), 1'b0, UNTYPED);
            end
        end
        calm = 1'b0;
        settle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_readouts.size() == 0) begin
            $display("PASS load_cell_weigh_and_tare_top");
        end else begin
            $display("FAIL load_cell_weigh_and_tare_top");
        end
        $finish;
    end

endmodule
